// ----- src/lifo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_pkg
// Shared types, field widths and operation and status codes for the LIFO
// stack with peek.
// ----------------------------------------------------------------------------
package lifo_pkg;

    localparam int DATA_W        = 32;
    localparam int MODE_W        = 3;
    localparam int POS_W         = 7;
    localparam int COUNT_W       = 7;
    localparam int STATUS_W      = 2;
    localparam int CAP_W         = 7;
    localparam int DEPTH_DEFAULT = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TOP    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BOTTOM = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS    = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
        logic                     full_res;
        logic                     empty_res;
    } result_t;

endpackage

// ----- src/lifo_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_mem
// Entry storage of the stack: one synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module lifo_mem #(
    parameter int DEPTH = lifo_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    waddr,
    input  logic [lifo_pkg::DATA_W-1:0] wdata,
    input  logic                        re,
    input  logic [$clog2(DEPTH)-1:0]    raddr,
    output logic [lifo_pkg::DATA_W-1:0] rdata
);

    logic [lifo_pkg::DATA_W-1:0] mem [DEPTH];
    logic [lifo_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/lifo_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_ctrl
// Fill count, capacity register, address generation and result formation
// for the LIFO stack.
// ----------------------------------------------------------------------------
module lifo_ctrl #(
    parameter int DEPTH = lifo_pkg::DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  lifo_pkg::cmd_t               cmd,
    output logic                         busy,
    output logic                         result_valid,
    output lifo_pkg::result_t            result,
    input  logic                         cfg_wr,
    input  logic [lifo_pkg::CAP_W-1:0]   cfg_data,
    output logic                         mem_we,
    output logic [$clog2(DEPTH)-1:0]     mem_waddr,
    output logic [lifo_pkg::DATA_W-1:0]  mem_wdata,
    output logic                         mem_re,
    output logic [$clog2(DEPTH)-1:0]     mem_raddr,
    input  logic [lifo_pkg::DATA_W-1:0]  mem_rdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int W     = (CNT_W > lifo_pkg::CAP_W) ? CNT_W : lifo_pkg::CAP_W;

    logic [lifo_pkg::CAP_W-1:0]    cap_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          busy_reg;
    logic                          use_mem_reg;
    logic                          use_mem_next;
    logic                          err_reg;
    logic                          err_next;
    logic [lifo_pkg::STATUS_W-1:0] status_reg;
    logic [lifo_pkg::STATUS_W-1:0] status_next;

    logic            go;
    logic [W-1:0]    cap_w;
    logic [W-1:0]    eff_cap;
    logic [W-1:0]    count_w;
    logic [W-1:0]    pos_w;
    logic [W-1:0]    peek_idx;
    logic            full_now;
    logic [AW-1:0]   raddr;

    assign go      = start && !busy_reg;
    assign cap_w   = W'(cap_reg);
    assign count_w = W'(count_reg);
    assign pos_w   = W'(cmd.position);
    assign peek_idx = count_w - pos_w;

    always_comb
    begin
        if (cap_w == '0)
        begin
            eff_cap = W'(1);
        end
        else if (cap_w > W'(DEPTH))
        begin
            eff_cap = W'(DEPTH);
        end
        else
        begin
            eff_cap = cap_w;
        end
    end

    assign full_now = (count_w >= eff_cap);

    always_comb
    begin
        count_next   = count_reg;
        use_mem_next = 1'b0;
        err_next     = 1'b0;
        status_next  = lifo_pkg::ST_OK;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        raddr        = '0;
        unique case (cmd.mode)
            lifo_pkg::MODE_PUSH:
            begin
                if (full_now)
                begin
                    status_next = lifo_pkg::ST_OVERFLOW;
                end
                else
                begin
                    mem_we     = go;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            lifo_pkg::MODE_POP:
            begin
                if (count_reg == '0)
                begin
                    status_next = lifo_pkg::ST_UNDERFLOW;
                    err_next    = 1'b1;
                end
                else
                begin
                    count_next   = count_reg - CNT_W'(1);
                    raddr        = AW'(count_reg - CNT_W'(1));
                    mem_re       = go;
                    use_mem_next = 1'b1;
                end
            end
            lifo_pkg::MODE_PEEK:
            begin
                if (pos_w == '0 || pos_w > count_w)
                begin
                    status_next = lifo_pkg::ST_BADPOS;
                    err_next    = 1'b1;
                end
                else
                begin
                    raddr        = peek_idx[AW-1:0];
                    mem_re       = go;
                    use_mem_next = 1'b1;
                end
            end
            lifo_pkg::MODE_TOP, lifo_pkg::MODE_BOTTOM:
            begin
                if (count_reg == '0)
                begin
                    status_next = lifo_pkg::ST_UNDERFLOW;
                    err_next    = 1'b1;
                end
                else
                begin
                    if (cmd.mode == lifo_pkg::MODE_TOP)
                    begin
                        raddr = AW'(count_reg - CNT_W'(1));
                    end
                    mem_re       = go;
                    use_mem_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign mem_waddr = count_reg[AW-1:0];
    assign mem_wdata = $unsigned(cmd.value);
    assign mem_raddr = raddr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= lifo_pkg::CAP_RESET;
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                cap_reg <= cfg_data;
            end
            if (go)
            begin
                busy_reg  <= 1'b1;
                count_reg <= count_next;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            use_mem_reg <= use_mem_next;
            err_reg     <= err_next;
            status_reg  <= status_next;
        end
    end

    assign busy         = busy_reg;
    assign result_valid = busy_reg;

    always_comb
    begin
        if (use_mem_reg)
        begin
            result.data = $signed(mem_rdata);
        end
        else if (err_reg)
        begin
            result.data = '1;
        end
        else
        begin
            result.data = '0;
        end
        result.status    = status_reg;
        result.count     = lifo_pkg::COUNT_W'(count_reg);
        result.full_res  = full_now;
        result.empty_res = (count_reg == '0);
    end

endmodule

// ----- src/lifo_stack_with_peek.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_peek
// Bounded LIFO stack of signed words with push, pop, peek, read top and read
// bottom operations, each returning one result item.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Handshake
//  command   start, busy, cmd               taken when start high, busy low
//  result    result_valid, result           one cycle, cannot be held off
//  config    cfg_valid, cfg_ready, cfg_data written when valid and ready
//
//  The memory is read or written at the accept edge, and the result appears
//  in the next cycle while busy is high; no new command is taken then.
//  The result waits on the registered read port of the entry memory.
//  Reset clears the fill count and sets the capacity to 64; entries need no
//  clearing pass. The configuration port is always ready.
// ----------------------------------------------------------------------------
module lifo_stack_with_peek #(
    parameter int DEPTH = lifo_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lifo_pkg::cmd_t             cmd,
    output logic                       result_valid,
    output lifo_pkg::result_t          result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lifo_pkg::CAP_W-1:0] cfg_data
);

    logic                        mem_we;
    logic [$clog2(DEPTH)-1:0]    mem_waddr;
    logic [lifo_pkg::DATA_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [$clog2(DEPTH)-1:0]    mem_raddr;
    logic [lifo_pkg::DATA_W-1:0] mem_rdata;

    assign cfg_ready = 1'b1;

    lifo_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .busy        (busy),
        .result_valid(result_valid),
        .result      (result),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    lifo_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

endmodule
